/* src/clcc_pkg.sv */
// Shared types and constants of the camera line capture chunker.
package clcc_pkg;

  // Request function codes on the input channel.
  localparam logic [1:0] FUNC_ARM   = 2'd0;
  localparam logic [1:0] FUNC_SYNC  = 2'd1;
  localparam logic [1:0] FUNC_PIXEL = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_CHUNK = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] CFG_MAX_LINES  = 1'b0;
  localparam logic [0:0] CFG_CHUNK_SIZE = 1'b1;

  localparam logic [9:0]  MAX_LINES_RESET  = 10'd290;
  localparam logic [10:0] CHUNK_SIZE_RESET = 11'd355;
  localparam logic [10:0] MIN_CHUNK        = 11'd64;
  localparam logic [3:0]  LAST_SEQ         = 4'd15;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_lines;  // frame start: zero the line count
    logic start_line;   // line start: zero pixel count and overflow
    logic pixel;        // store a pixel byte or flag overflow
    logic line_end;     // bump line count, set up chunk walk
    logic read_issue;   // launch a line store read
    logic load_read;    // put read data into the output register
    logic load_frame;   // put frame done into the output register
    logic load_chunk;   // put next chunk into the output register, advance
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic frame_end;    // next line end completes the frame
    logic line_empty;   // no bytes stored on the current line
    logic chunk_last;   // the pending chunk is the final one
  } status_t;

endpackage

/* src/clcc_ctrl.sv */
// Controller: sync phase tracking and request sequencing.
module clcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          func,
  output logic                in_ready,
  input  clcc_pkg::status_t   st,
  output clcc_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHUNK
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FRAME,
    PH_LINE,
    PH_IN
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            clcc_pkg::FUNC_ARM: begin
              if (phase == PH_IDLE) phase_next = PH_FRAME;
            end
            clcc_pkg::FUNC_SYNC: begin
              case (phase)
                PH_FRAME: begin
                  cmd.clear_lines = 1'b1;
                  phase_next      = PH_LINE;
                end
                PH_LINE: begin
                  cmd.start_line = 1'b1;
                  phase_next     = PH_IN;
                end
                PH_IN: begin
                  cmd.line_end = 1'b1;
                  if (st.frame_end) begin
                    cmd.load_frame = 1'b1;
                    phase_next     = PH_IDLE;
                  end else begin
                    phase_next = PH_LINE;
                    if (!st.line_empty) state_next = S_CHUNK;
                  end
                end
                default: begin
                  phase_next = phase;
                end
              endcase
            end
            clcc_pkg::FUNC_PIXEL: begin
              if (phase == PH_IN) cmd.pixel = 1'b1;
            end
            default: begin
              cmd.read_issue = 1'b1;
              state_next     = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        if (st.out_free) begin
          cmd.load_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CHUNK: begin
        if (st.out_free) begin
          cmd.load_chunk = 1'b1;
          if (st.chunk_last) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

/* src/clcc_datapath.sv */
// Datapath: config registers, counters, line store, chunk walk and output register.
module clcc_datapath #(
  parameter int LINE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [0:0]          cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic [7:0]          pixel_data,
  input  logic [9:0]          read_address,
  input  clcc_pkg::cmd_t      cmd,
  output clcc_pkg::status_t   st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [7:0]          read_data,
  output logic [9:0]          line_index,
  output logic [3:0]          chunk_seq,
  output logic [9:0]          chunk_offset,
  output logic [10:0]         chunk_length,
  output logic                last,
  output logic                overflow
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = $clog2(LINE_DEPTH + 1);
  localparam int LW = (PW > 11) ? PW : 11;
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;

  logic [9:0]    max_lines;
  logic [10:0]   chunk_size;
  logic [9:0]    line_count;
  logic [9:0]    line_count_inc;
  logic [PW-1:0] pixel_count;
  logic          overflow_flag;
  logic          line_full;

  logic [7:0]    line_store [LINE_DEPTH];
  logic [7:0]    rd_q;
  logic          rd_ok;
  logic [CW-1:0] addr_ext;

  logic [PW-1:0] left;
  logic [PW-1:0] off;
  logic [3:0]    seq;
  logic [10:0]   step;
  logic [LW-1:0] left_ext;
  logic [LW-1:0] step_ext;
  logic [LW-1:0] len;
  logic          out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lines  <= clcc_pkg::MAX_LINES_RESET;
      chunk_size <= clcc_pkg::CHUNK_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        clcc_pkg::CFG_MAX_LINES:  max_lines  <= cfg_data[9:0];
        clcc_pkg::CFG_CHUNK_SIZE: chunk_size <= cfg_data;
        default: begin
          max_lines <= max_lines;
        end
      endcase
    end
  end

  assign line_count_inc = line_count + 10'd1;
  assign line_full      = (pixel_count >= PW'(LINE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      pixel_count   <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.clear_lines) line_count <= '0;
      if (cmd.line_end)    line_count <= line_count_inc;
      if (cmd.start_line) begin
        pixel_count   <= '0;
        overflow_flag <= 1'b0;
      end
      if (cmd.pixel) begin
        if (line_full) overflow_flag <= 1'b1;
        else           pixel_count   <= pixel_count + PW'(1);
      end
    end
  end

  // Line store: one write port for pixels, one registered read port.
  assign addr_ext = CW'(read_address);

  always_ff @(posedge clk) begin
    if (cmd.pixel && !line_full) line_store[pixel_count[AW-1:0]] <= pixel_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      rd_q  <= line_store[addr_ext[AW-1:0]];
      rd_ok <= (addr_ext < CW'(LINE_DEPTH));
    end
  end

  // Chunk walk: one chunk per step of the shared compare and subtract.
  assign step     = (chunk_size < clcc_pkg::MIN_CHUNK) ? clcc_pkg::MIN_CHUNK : chunk_size;
  assign left_ext = LW'(left);
  assign step_ext = LW'(step);
  assign len      = (left_ext > step_ext) ? step_ext : left_ext;

  always_ff @(posedge clk) begin
    if (cmd.line_end) begin
      left <= pixel_count;
      off  <= '0;
      seq  <= '0;
    end else if (cmd.load_chunk) begin
      left <= left - PW'(len);
      off  <= off + PW'(len);
      seq  <= seq + 4'd1;
    end
  end

  assign out_load = cmd.load_read || cmd.load_frame || cmd.load_chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= clcc_pkg::KIND_READ;
      read_data    <= '0;
      line_index   <= '0;
      chunk_seq    <= '0;
      chunk_offset <= '0;
      chunk_length <= '0;
      last         <= 1'b1;
      overflow     <= 1'b0;
      if (cmd.load_read) begin
        read_data <= rd_ok ? rd_q : 8'd0;
      end else if (cmd.load_frame) begin
        kind       <= clcc_pkg::KIND_FRAME;
        line_index <= line_count_inc;
        overflow   <= overflow_flag;
      end else begin
        kind         <= clcc_pkg::KIND_CHUNK;
        line_index   <= line_count;
        chunk_seq    <= seq;
        chunk_offset <= 10'(off);
        chunk_length <= len[10:0];
        last         <= st.chunk_last;
        overflow     <= overflow_flag;
      end
    end
  end

  assign st.out_free   = !out_valid || out_ready;
  assign st.frame_end  = (line_count_inc >= max_lines);
  assign st.line_empty = (pixel_count == '0);
  assign st.chunk_last = (left_ext <= step_ext) || (seq == clcc_pkg::LAST_SEQ);

endmodule

/* src/camera_line_capture_chunker.sv */
// Top level of the parallel camera line capture and chunking block.
//
//   Channel  Signals                                         Direction  Handshake
//   input    func, pixel_data, read_address                  in         in_valid / in_ready
//   output   kind, read_data, line_index, chunk_seq,         out        out_valid / out_ready
//            chunk_offset, chunk_length, last, overflow
//   config   cfg_index, cfg_data                             in         cfg_write (no wait)
//
// Requests are accepted while the controller is idle and the output register is
// free, so a line of pixels streams in at one byte per clock while nothing stalls.
// In a read, the line store read is registered, then the byte moves to the
// output register. After a line end that yields chunk descriptors, the chunk walk
// emits one descriptor per cycle while the output side keeps taking them.
// rst (synchronous) clears the sync phase, counters and output valid; the line
// store is not cleared. A stalled output holds the result and blocks new requests.
module camera_line_capture_chunker #(
  parameter int LINE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  pixel_data,
  input  logic [9:0]  read_address,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  read_data,
  output logic [9:0]  line_index,
  output logic [3:0]  chunk_seq,
  output logic [9:0]  chunk_offset,
  output logic [10:0] chunk_length,
  output logic        last,
  output logic        overflow,
  // configuration write port
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  clcc_pkg::cmd_t    cmd;
  clcc_pkg::status_t st;

  // Controller: tracks the sync phase (idle, wait frame, wait line, in line)
  // and sequences reads and chunk walks.
  clcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: config registers, line and pixel counters, line store,
  // chunk walk and the output register that decouples the result side.
  clcc_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_data   (pixel_data),
    .read_address (read_address),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .read_data    (read_data),
    .line_index   (line_index),
    .chunk_seq    (chunk_seq),
    .chunk_offset (chunk_offset),
    .chunk_length (chunk_length),
    .last         (last),
    .overflow     (overflow)
  );

endmodule
